FILE: rtl/rscc_pkg.sv
// ---------------------------------------------------------------------------
// rscc_pkg
// Shared types and constants of the single-cycle RISC subset core: function
// codes, opcodes, funct codes, data memory geometry and the memory request.
// ---------------------------------------------------------------------------
`default_nettype none

package rscc_pkg;

   localparam int unsigned DMEM_BYTES = 65536;
   localparam int unsigned DMEM_AW    = $clog2(DMEM_BYTES);
   localparam int unsigned LANE_AW    = DMEM_AW - 2;
   localparam int unsigned LANE_DEPTH = DMEM_BYTES / 4;
   localparam int unsigned NUM_REGS   = 32;
   localparam int unsigned REG_AW     = $clog2(NUM_REGS);

   typedef enum logic [1:0] {
      FUNC_EXEC    = 2'd0,
      FUNC_PRELOAD = 2'd1,
      FUNC_READ    = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [5:0] {
      OP_RTYPE = 6'b000000,
      OP_ADDIU = 6'b001001,
      OP_LW    = 6'b100011,
      OP_SW    = 6'b101011,
      OP_J     = 6'b000010,
      OP_BEQ   = 6'b000100,
      OP_HALT  = 6'b111111
   } opcode_type;

   localparam logic [2:0] FN_ADDU = 3'd1;
   localparam logic [2:0] FN_SUBU = 3'd3;
   localparam logic [2:0] FN_AND  = 3'd4;
   localparam logic [2:0] FN_OR   = 3'd5;
   localparam logic [2:0] FN_NOR  = 3'd7;

   typedef struct packed {
      logic               en;
      logic               we;
      logic [DMEM_AW-1:0] addr;
      logic [31:0]        wdata;
   } dmem_req_type;

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rscc_req_if.sv
// ---------------------------------------------------------------------------
// rscc_req_if
// Request channel: one item per transfer (execute, preload or read).
// ---------------------------------------------------------------------------
`default_nettype none

interface rscc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] instr;
   logic [15:0] mem_addr;
   logic [31:0] mem_word;

   modport source (output valid, func, instr, mem_addr, mem_word, input ready);
   modport sink   (input valid, func, instr, mem_addr, mem_word, output ready);
endinterface

`default_nettype wire

FILE: rtl/rscc_rsp_if.sv
// ---------------------------------------------------------------------------
// rscc_rsp_if
// Response channel: one result per request transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface rscc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic        halted;
   logic        reg_written;
   logic [4:0]  reg_index;
   logic [31:0] reg_value;
   logic        store_done;
   logic [31:0] read_word;

   modport source (output valid, next_pc, halted, reg_written, reg_index, reg_value,
                   store_done, read_word, input ready);
   modport sink   (input valid, next_pc, halted, reg_written, reg_index, reg_value,
                   store_done, read_word, output ready);
endinterface

`default_nettype wire

FILE: rtl/rscc_dmem.sv
// ---------------------------------------------------------------------------
// rscc_dmem
// Byte data memory as four byte lanes; one big-endian word access per cycle
// at any byte address, wrapping at the top. Read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module rscc_dmem (
   input  logic                  clock,
   input  rscc_pkg::dmem_req_type dmem_req,
   output logic [31:0]           rd_word
);
   import rscc_pkg::*;

   logic [7:0] lane_q [4];
   logic [1:0] off_ff;

   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [7:0]         mem [LANE_DEPTH];
      logic [7:0]         q_ff;
      logic [1:0]         k;
      logic               carry;
      logic [LANE_AW-1:0] idx;
      logic [7:0]         wbyte;

      assign k     = 2'(l) - dmem_req.addr[1:0];
      assign carry = 2'(l) < dmem_req.addr[1:0];
      assign idx   = dmem_req.addr[DMEM_AW-1:2] + {{(LANE_AW-1){1'b0}}, carry};
      assign wbyte = dmem_req.wdata[{~k, 3'b000} +: 8];

      always_ff @(posedge clock) begin
         if (dmem_req.en) begin
            if (dmem_req.we) begin
               mem[idx] <= wbyte;
            end
            q_ff <= mem[idx];
         end
      end

      assign lane_q[l] = q_ff;
   end

   always_ff @(posedge clock) begin
      if (dmem_req.en) begin
         off_ff <= dmem_req.addr[1:0];
      end
   end

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < 4; i++) begin
         rd_word[8*(3-i) +: 8] = lane_q[off_ff + 2'(i)];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/risc_subset_single_cycle_core.sv
// ---------------------------------------------------------------------------
// risc_subset_single_cycle_core
// Processor core for a small RISC subset: register file, byte data memory,
// program counter and halt flag, driven one item per request transfer.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per transfer: execute the given instruction at
//   the current PC, preload a big-endian data word, or read one back.
//   rsp_chan returns exactly one result per item, in order.
//   A request transfer passes the operand read stage, then the memory/output
//   stage, where its result is valid. One item per cycle while rsp_chan
//   does not stall; the single data memory port serves one word access per
//   item, and results of earlier items are forwarded to the operand stage,
//   so dependent instructions follow back to back.
//   Reset (synchronous, active high) clears the PC, the halt flag, the
//   register file valid bits and both pipeline stages; data memory keeps
//   whatever it holds and reads undefined until written.
//   When rsp_chan stalls, the result stays in the output stage and one more
//   item is taken into the operand stage; after that req_chan.ready drops
//   until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module risc_subset_single_cycle_core (
   input  logic        clock,
   input  logic        reset,
   rscc_req_if.sink    req_chan,
   rscc_rsp_if.source  rsp_chan
);
   import rscc_pkg::*;

   logic adv;
   logic acc;
   logic e1_move;

   // operand stage
   logic        e1_valid_ff;
   logic [1:0]  e1_func_ff;
   logic [31:0] e1_instr_ff;
   logic [15:0] e1_addr_ff;
   logic [31:0] e1_word_ff;

   // register file
   logic [31:0]         rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0] rf_valid_ff;
   logic [31:0]         rf_a_ff;
   logic [31:0]         rf_b_ff;
   logic                rf_va_ff;
   logic                rf_vb_ff;
   logic                rf_we;
   logic [REG_AW-1:0]   rf_widx;
   logic [31:0]         rf_wdata;
   logic                byp_valid_ff;
   logic [REG_AW-1:0]   byp_idx_ff;
   logic [31:0]         byp_val_ff;

   // architectural control
   logic [31:0] pc_ff;
   logic [31:0] pc_in;
   logic        halt_ff;
   logic        halt_in;

   // output stage
   logic              e2_valid_ff;
   logic              e2_wr_ff;
   logic [REG_AW-1:0] e2_idx_ff;
   logic [31:0]       e2_alu_ff;
   logic              e2_load_ff;
   logic              e2_store_ff;
   logic              e2_read_ff;
   logic [31:0]       e2_pc_ff;
   logic              e2_halt_ff;
   logic [31:0]       e2_value;

   // execute
   logic [REG_AW-1:0] rs;
   logic [REG_AW-1:0] rt;
   logic [REG_AW-1:0] rd;
   logic [31:0]       opa;
   logic [31:0]       opb;
   logic [31:0]       imm;
   logic [31:0]       pc4;
   logic [31:0]       eff_addr;
   logic              exec;
   logic              wr;
   logic [REG_AW-1:0] widx;
   logic [31:0]       alu;
   logic              load;
   logic              store;

   dmem_req_type dmem_req;
   logic [31:0]  dmem_rdata;

   assign adv            = !e2_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !e1_valid_ff || adv;
   assign acc            = req_chan.valid && req_chan.ready;
   assign e1_move        = e1_valid_ff && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (acc) begin
         e1_valid_ff <= 1'b1;
      end else if (e1_move) begin
         e1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         e1_func_ff   <= req_chan.func;
         e1_instr_ff  <= req_chan.instr;
         e1_addr_ff   <= req_chan.mem_addr;
         e1_word_ff   <= req_chan.mem_word;
         rf_va_ff     <= rf_valid_ff[req_chan.instr[25:21]];
         rf_vb_ff     <= rf_valid_ff[req_chan.instr[20:16]];
         byp_valid_ff <= rf_we;
         byp_idx_ff   <= rf_widx;
         byp_val_ff   <= rf_wdata;
      end
   end

   // register file: write from the output stage, read on request transfer
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_widx] <= rf_wdata;
      end
      if (acc) begin
         rf_a_ff <= rf_mem[req_chan.instr[25:21]];
         rf_b_ff <= rf_mem[req_chan.instr[20:16]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (rf_we) begin
         rf_valid_ff[rf_widx] <= 1'b1;
      end
   end

   assign e2_value = e2_load_ff ? dmem_rdata : e2_alu_ff;
   assign rf_we    = e2_valid_ff && rsp_chan.ready && e2_wr_ff;
   assign rf_widx  = e2_idx_ff;
   assign rf_wdata = e2_value;

   assign rs = e1_instr_ff[25:21];
   assign rt = e1_instr_ff[20:16];
   assign rd = e1_instr_ff[15:11];

   // forward: output stage, then the write seen at read time, then the file
   always_comb begin
      if (e2_valid_ff && e2_wr_ff && e2_idx_ff == rs) begin
         opa = e2_value;
      end else if (byp_valid_ff && byp_idx_ff == rs) begin
         opa = byp_val_ff;
      end else if (rf_va_ff) begin
         opa = rf_a_ff;
      end else begin
         opa = '0;
      end
      if (e2_valid_ff && e2_wr_ff && e2_idx_ff == rt) begin
         opb = e2_value;
      end else if (byp_valid_ff && byp_idx_ff == rt) begin
         opb = byp_val_ff;
      end else if (rf_vb_ff) begin
         opb = rf_b_ff;
      end else begin
         opb = '0;
      end
   end

   assign imm      = sext16(e1_instr_ff[15:0]);
   assign pc4      = pc_ff + 32'd4;
   assign eff_addr = opa + imm;
   assign exec     = (e1_func_ff == FUNC_EXEC) && !halt_ff;

   always_comb begin
      wr             = 1'b0;
      widx           = '0;
      alu            = '0;
      load           = 1'b0;
      store          = 1'b0;
      pc_in          = pc_ff;
      halt_in        = halt_ff;
      dmem_req.en    = e1_move;
      dmem_req.we    = e1_move && (e1_func_ff == FUNC_PRELOAD);
      dmem_req.addr  = DMEM_AW'(e1_addr_ff);
      dmem_req.wdata = e1_word_ff;
      if (exec) begin
         pc_in = pc4;
         case (e1_instr_ff[31:26])
            OP_RTYPE: begin
               widx = rd;
               wr   = 1'b1;
               case (e1_instr_ff[2:0])
                  FN_ADDU: alu = opa + opb;
                  FN_SUBU: alu = opa - opb;
                  FN_AND:  alu = opa & opb;
                  FN_OR:   alu = opa | opb;
                  FN_NOR:  alu = ~(opa | opb);
                  default: wr = 1'b0;
               endcase
            end
            OP_ADDIU: begin
               widx = rt;
               alu  = eff_addr;
               wr   = 1'b1;
            end
            OP_LW: begin
               widx          = rt;
               wr            = 1'b1;
               load          = 1'b1;
               dmem_req.addr = DMEM_AW'(eff_addr);
            end
            OP_SW: begin
               store          = 1'b1;
               dmem_req.addr  = DMEM_AW'(eff_addr);
               dmem_req.wdata = opb;
               dmem_req.we    = e1_move;
            end
            OP_J: begin
               pc_in = {pc4[31:28], e1_instr_ff[25:0], 2'b00};
            end
            OP_BEQ: begin
               if (opa == opb) begin
                  pc_in = pc4 + {imm[29:0], 2'b00};
               end
            end
            OP_HALT: begin
               halt_in = 1'b1;
               pc_in   = pc_ff;
            end
            default: begin
               pc_in = pc4;
            end
         endcase
         // register zero: drop the write
         if (wr && widx == '0) begin
            wr = 1'b0;
         end
         if (!wr) begin
            widx = '0;
            alu  = '0;
            load = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         halt_ff <= 1'b0;
      end else if (e1_move) begin
         pc_ff   <= pc_in;
         halt_ff <= halt_in;
      end
   end

   rscc_dmem u_dmem (
      .clock    (clock),
      .dmem_req (dmem_req),
      .rd_word  (dmem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else if (adv) begin
         e2_valid_ff <= e1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (e1_move) begin
         e2_wr_ff    <= wr;
         e2_idx_ff   <= widx;
         e2_alu_ff   <= alu;
         e2_load_ff  <= load;
         e2_store_ff <= store;
         e2_read_ff  <= (e1_func_ff == FUNC_READ);
         e2_pc_ff    <= pc_in;
         e2_halt_ff  <= halt_in;
      end
   end

   assign rsp_chan.valid       = e2_valid_ff;
   assign rsp_chan.next_pc     = e2_pc_ff;
   assign rsp_chan.halted      = e2_halt_ff;
   assign rsp_chan.reg_written = e2_wr_ff;
   assign rsp_chan.reg_index   = e2_idx_ff;
   assign rsp_chan.reg_value   = e2_value;
   assign rsp_chan.store_done  = e2_store_ff;
   assign rsp_chan.read_word   = e2_read_ff ? dmem_rdata : '0;

endmodule

`default_nettype wire

FILE: rtl/rscc_checker.sv
// ---------------------------------------------------------------------------
// rscc_checker
// Port-level checks of the core's response channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module rscc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] next_pc,
   input logic        halted,
   input logic        reg_written,
   input logic [4:0]  reg_index,
   input logic [31:0] reg_value,
   input logic        store_done,
   input logic [31:0] read_word
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(next_pc) && $stable(reg_value)
         && $stable(read_word))
      else $error("response changed while stalled");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_no_write_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !reg_written |-> reg_index == 5'd0 && reg_value == 32'd0)
      else $error("write-back fields set without a register write");

   a_halted_quiet : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && halted |-> !reg_written && !store_done)
      else $error("halted core wrote state");

   a_store_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && store_done |-> !reg_written && read_word == 32'd0)
      else $error("store reported with a write-back or read word");

endmodule

bind risc_subset_single_cycle_core rscc_checker u_rscc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .next_pc     (rsp_chan.next_pc),
   .halted      (rsp_chan.halted),
   .reg_written (rsp_chan.reg_written),
   .reg_index   (rsp_chan.reg_index),
   .reg_value   (rsp_chan.reg_value),
   .store_done  (rsp_chan.store_done),
   .read_word   (rsp_chan.read_word)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the single-cycle RISC subset core. A planner
// builds the instruction and memory stream up front against its own copy of
// the core state, so loads and reads only touch bytes already written. The
// driver offers the stream with random gaps. Each transfer updates a second
// copy of the state, and the predicted result is queued. The monitor stalls
// at random and compares every result field against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import rscc_pkg::*;

   localparam int unsigned PLAN = 0;
   localparam int unsigned LIVE = 1;
   localparam int unsigned RANDOM_ITEMS = 700;
   localparam logic [5:0] OP_UNUSED = 6'b111110;

   typedef struct packed {
      func_type    func;
      logic [31:0] instr;
      logic [15:0] mem_addr;
      logic [31:0] mem_word;
      logic        drain_first;
   } core_item_t;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        store_done;
      logic [31:0] read_word;
   } outcome_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic [1:0]  req_func = FUNC_EXEC;
   logic [31:0] req_instr = '0;
   logic [15:0] req_addr = '0;
   logic [31:0] req_word = '0;
   logic        rsp_ready = 1'b0;

   rscc_req_if req_chan ();
   rscc_rsp_if rsp_chan ();

   assign req_chan.valid    = req_valid;
   assign req_chan.func     = req_func;
   assign req_chan.instr    = req_instr;
   assign req_chan.mem_addr = req_addr;
   assign req_chan.mem_word = req_word;
   assign rsp_chan.ready    = rsp_ready;

   risc_subset_single_cycle_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #6 clock = ~clock;

   // two copies of the core state: one for planning the stream, one for checking
   logic [31:0] core_gpr [2][NUM_REGS];
   logic [7:0]  core_mem [2][DMEM_BYTES];
   bit          mem_known [2][DMEM_BYTES];
   logic [31:0] core_pc [2];
   logic        core_halted [2];

   core_item_t  program_items[$];
   outcome_t    predicted_results[$];
   logic [15:0] stored_addrs[$];

   core_item_t  offered_item;
   int unsigned items_sent = 0;
   int unsigned idle_left = 0;
   int unsigned results_seen = 0;
   int unsigned stall_left = 0;
   int unsigned rx_cycles = 0;
   bit          long_hold_done = 1'b0;
   int unsigned mismatches = 0;

   function automatic logic [31:0] get_word(input int unsigned s,
                                            input logic [DMEM_AW-1:0] addr);
      logic [31:0] w;
      logic [DMEM_AW-1:0] p;
      w = '0;
      p = addr;
      for (int k = 0; k < 4; k++) begin
         w = {w[23:0], core_mem[s][p]};
         p = p + 1'b1;
      end
      return w;
   endfunction

   function automatic void put_word(input int unsigned s, input logic [DMEM_AW-1:0] addr,
                                    input logic [31:0] word);
      logic [31:0] w;
      logic [DMEM_AW-1:0] p;
      w = word;
      p = addr;
      for (int k = 0; k < 4; k++) begin
         core_mem[s][p] = w[31:24];
         mem_known[s][p] = 1'b1;
         w = w << 8;
         p = p + 1'b1;
      end
   endfunction

   function automatic bit word_known(input int unsigned s, input logic [DMEM_AW-1:0] addr);
      logic [DMEM_AW-1:0] p;
      bit all_set;
      p = addr;
      all_set = 1'b1;
      for (int k = 0; k < 4; k++) begin
         all_set = all_set & mem_known[s][p];
         p = p + 1'b1;
      end
      return all_set;
   endfunction

   function automatic outcome_t execute_item(input int unsigned s, input core_item_t it);
      outcome_t    r;
      logic [5:0]  op;
      logic [4:0]  rs, rt, rd, widx;
      logic [31:0] a, b, imm, ea, pc4, npc, wval;
      logic        wr;
      r = '0;
      wr = 1'b0;
      widx = '0;
      wval = '0;
      op = it.instr[31:26];
      rs = it.instr[25:21];
      rt = it.instr[20:16];
      rd = it.instr[15:11];
      imm = {{16{it.instr[15]}}, it.instr[15:0]};
      a = core_gpr[s][rs];
      b = core_gpr[s][rt];
      ea = a + imm;
      case (it.func)
         FUNC_PRELOAD: put_word(s, it.mem_addr, it.mem_word);
         FUNC_READ: r.read_word = get_word(s, it.mem_addr);
         FUNC_EXEC: begin
            if (!core_halted[s]) begin
               pc4 = core_pc[s] + 32'd4;
               npc = pc4;
               case (op)
                  OP_RTYPE: begin
                     widx = rd;
                     wr = 1'b1;
                     case (it.instr[2:0])
                        FN_ADDU: wval = a + b;
                        FN_SUBU: wval = a - b;
                        FN_AND:  wval = a & b;
                        FN_OR:   wval = a | b;
                        FN_NOR:  wval = ~(a | b);
                        default: wr = 1'b0;
                     endcase
                  end
                  OP_ADDIU: begin
                     widx = rt;
                     wval = ea;
                     wr = 1'b1;
                  end
                  OP_LW: begin
                     widx = rt;
                     wval = get_word(s, ea[DMEM_AW-1:0]);
                     wr = 1'b1;
                  end
                  OP_SW: begin
                     put_word(s, ea[DMEM_AW-1:0], b);
                     r.store_done = 1'b1;
                  end
                  OP_J: npc = {pc4[31:28], it.instr[25:0], 2'b00};
                  OP_BEQ: begin
                     if (a == b) npc = pc4 + {imm[29:0], 2'b00};
                  end
                  OP_HALT: begin
                     core_halted[s] = 1'b1;
                     npc = core_pc[s];
                  end
                  default: ;
               endcase
               if (wr && widx != '0) begin
                  core_gpr[s][widx] = wval;
               end else begin
                  wr = 1'b0;
                  widx = '0;
                  wval = '0;
               end
               core_pc[s] = npc;
            end
         end
         default: ;
      endcase
      r.next_pc = core_pc[s];
      r.halted = core_halted[s];
      r.reg_written = wr;
      r.reg_index = widx;
      r.reg_value = wval;
      return r;
   endfunction

   function automatic core_item_t exec_item(input logic [31:0] instr);
      core_item_t it;
      it = '0;
      it.func = FUNC_EXEC;
      it.instr = instr;
      it.mem_addr = 16'($urandom);
      it.mem_word = $urandom;
      return it;
   endfunction

   function automatic core_item_t mem_item(input func_type f, input logic [15:0] addr,
                                           input logic [31:0] word);
      core_item_t it;
      it = '0;
      it.func = f;
      it.instr = $urandom;
      it.mem_addr = addr;
      it.mem_word = word;
      return it;
   endfunction

   function automatic logic [31:0] i_type(input opcode_type op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] r_type(input logic [2:0] fn, input logic [4:0] rd,
                                          input logic [4:0] rs, input logic [4:0] rt);
      return {OP_RTYPE, rs, rt, rd, 8'h00, fn};
   endfunction

   function automatic logic [15:0] known_addr();
      logic [15:0] base, shifted;
      base = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
      shifted = base + 16'($urandom_range(0, 3));
      return word_known(PLAN, shifted) ? shifted : base;
   endfunction

   function automatic logic [31:0] lw_instr(input logic [4:0] rs, input logic [4:0] rt,
                                            input logic [15:0] target);
      logic [15:0] offset;
      offset = target - core_gpr[PLAN][rs][15:0];
      return {OP_LW, rs, rt, offset};
   endfunction

   function automatic logic [4:0] pick_reg();
      return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom);
   endfunction

   // steer loads and reads onto written bytes, then advance the planning state
   function automatic void plan_item(input core_item_t it, input bit drain);
      logic [31:0] ea;
      ea = core_gpr[PLAN][it.instr[25:21]] + {{16{it.instr[15]}}, it.instr[15:0]};
      if (it.func == FUNC_EXEC && !core_halted[PLAN]) begin
         if (it.instr[31:26] == OP_LW && !word_known(PLAN, ea[15:0]))
            it.instr = lw_instr(it.instr[25:21], it.instr[20:16], known_addr());
         if (it.instr[31:26] == OP_SW) stored_addrs.push_back(ea[15:0]);
      end
      if (it.func == FUNC_READ && !word_known(PLAN, it.mem_addr)) it.mem_addr = known_addr();
      if (it.func == FUNC_PRELOAD) stored_addrs.push_back(it.mem_addr);
      it.drain_first = drain;
      void'(execute_item(PLAN, it));
      program_items.push_back(it);
   endfunction

   function automatic core_item_t random_item();
      core_item_t  it;
      logic [4:0]  rs, rt, rd;
      logic [15:0] imm;
      int unsigned pick;
      rs = pick_reg();
      rt = pick_reg();
      rd = pick_reg();
      imm = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 31)) - 16'd16 : 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         it = mem_item(func_type'($urandom_range(0, 3)), 16'($urandom), $urandom);
         if (it.instr[31:26] == OP_HALT) it.instr[26] = 1'b0;
      end else if (pick < 16) begin
         it = mem_item(FUNC_PRELOAD, ($urandom_range(0, 3) == 0) ?
                       16'hFFFC + 16'($urandom_range(0, 3)) : 16'($urandom), $urandom);
      end else if (pick < 22) begin
         it = mem_item(FUNC_READ, known_addr(), $urandom);
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2: it = exec_item({OP_RTYPE, rs, rt, rd, 11'($urandom)});
            3, 4:    it = exec_item(i_type(OP_ADDIU, rs, rt, imm));
            5, 6:    it = exec_item(lw_instr(rs, rt, ($urandom_range(0, 9) < 4) ?
                                             stored_addrs[$] : known_addr()));
            7:       it = exec_item(i_type(OP_SW, rs, rt, imm));
            8:       it = exec_item(i_type(OP_BEQ, rs, ($urandom_range(0, 1) == 0) ? rs : rt,
                                           imm));
            default: it = exec_item({OP_J, 26'($urandom)});
         endcase
      end
      return it;
   endfunction

   function automatic int unsigned sender_gap();
      if ((items_sent / 80) % 3 == 1) return 0;
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_valid && req_chan.ready) begin
            predicted_results.push_back(execute_item(LIVE, offered_item));
            items_sent++;
            idle_left = sender_gap();
         end
         if (req_valid && !req_chan.ready) begin
            // hold the current offer
         end else if (idle_left > 0) begin
            idle_left--;
            req_valid <= 1'b0;
         end else if (program_items.size() != 0 &&
                      !(program_items[0].drain_first && predicted_results.size() != 0)) begin
            offered_item = program_items.pop_front();
            req_valid <= 1'b1;
            req_func  <= offered_item.func;
            req_instr <= offered_item.instr;
            req_addr  <= offered_item.mem_addr;
            req_word  <= offered_item.mem_word;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      outcome_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         rx_cycles++;
         if (rsp_chan.valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $error("result transfer with no prediction pending");
               mismatches++;
            end else begin
               want = predicted_results.pop_front();
               check_field("next_pc", want.next_pc, rsp_chan.next_pc);
               check_field("halted", 32'(want.halted), 32'(rsp_chan.halted));
               check_field("reg_written", 32'(want.reg_written), 32'(rsp_chan.reg_written));
               check_field("reg_index", 32'(want.reg_index), 32'(rsp_chan.reg_index));
               check_field("reg_value", want.reg_value, rsp_chan.reg_value);
               check_field("store_done", 32'(want.store_done), 32'(rsp_chan.store_done));
               check_field("read_word", want.read_word, rsp_chan.read_word);
            end
            results_seen++;
         end
         if (!long_hold_done && results_seen >= 300) begin
            long_hold_done = 1'b1;
            stall_left = 150;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if ((rx_cycles / 256) % 4 == 3 || $urandom_range(0, 9) < 7) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) :
                         $urandom_range(10, 30);
            rsp_ready <= 1'b0;
         end
      end
   end

   initial begin
      for (int s = 0; s < 2; s++) begin
         core_pc[s] = '0;
         core_halted[s] = 1'b0;
         for (int r = 0; r < NUM_REGS; r++) core_gpr[s][r] = '0;
      end

      plan_item(mem_item(FUNC_PRELOAD, 16'h0000, 32'hFFFF_FFFF), 1'b0);
      plan_item(mem_item(FUNC_PRELOAD, 16'hFFFE, 32'h8001_7FFE), 1'b0);
      plan_item(mem_item(FUNC_PRELOAD, 16'h0100, 32'h0000_0000), 1'b0);
      plan_item(mem_item(FUNC_READ, 16'h0000, 32'h0), 1'b0);
      plan_item(mem_item(FUNC_READ, 16'hFFFE, 32'hFFFF_FFFF), 1'b0);
      plan_item(mem_item(FUNC_READ, 16'hFFFF, 32'h0), 1'b0);
      plan_item(mem_item(FUNC_NONE, 16'hFFFF, 32'hFFFF_FFFF), 1'b0);
      plan_item(exec_item(i_type(OP_ADDIU, 5'd0, 5'd1, 16'h7FFF)), 1'b0);
      plan_item(exec_item(i_type(OP_ADDIU, 5'd0, 5'd2, 16'h8000)), 1'b0);
      plan_item(exec_item(i_type(OP_ADDIU, 5'd1, 5'd0, 16'h0001)), 1'b0);
      plan_item(exec_item(r_type(FN_ADDU, 5'd3, 5'd1, 5'd2)), 1'b0);
      plan_item(exec_item(r_type(FN_SUBU, 5'd4, 5'd0, 5'd1)), 1'b0);
      plan_item(exec_item(r_type(FN_AND, 5'd5, 5'd4, 5'd2)), 1'b0);
      plan_item(exec_item(r_type(FN_OR, 5'd6, 5'd1, 5'd2)), 1'b0);
      plan_item(exec_item(r_type(FN_NOR, 5'd7, 5'd0, 5'd0)), 1'b0);
      plan_item(exec_item(r_type(FN_ADDU, 5'd8, 5'd7, 5'd7)), 1'b0);
      plan_item(exec_item(r_type(3'd0, 5'd9, 5'd7, 5'd7)), 1'b0);
      plan_item(exec_item(r_type(3'd6, 5'd9, 5'd1, 5'd7)), 1'b0);
      plan_item(exec_item(i_type(OP_LW, 5'd0, 5'd10, 16'hFFFF)), 1'b0);
      plan_item(exec_item(i_type(OP_SW, 5'd0, 5'd7, 16'h0100)), 1'b0);
      plan_item(exec_item(i_type(OP_LW, 5'd0, 5'd11, 16'h0100)), 1'b0);
      plan_item(exec_item(i_type(OP_SW, 5'd0, 5'd3, 16'hFFFE)), 1'b0);
      plan_item(exec_item(i_type(OP_LW, 5'd1, 5'd12, 16'h7FFF)), 1'b0);
      plan_item(exec_item(i_type(OP_BEQ, 5'd1, 5'd1, 16'hFFFD)), 1'b0);
      plan_item(exec_item(i_type(OP_BEQ, 5'd1, 5'd2, 16'h0005)), 1'b0);
      plan_item(exec_item({OP_J, 26'h3FF_FFFF}), 1'b0);
      plan_item(exec_item({OP_UNUSED, 26'h2AA_5555}), 1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++)
         plan_item(random_item(), n == 0 || n == RANDOM_ITEMS / 2);

      plan_item(exec_item({OP_HALT, 26'h155_AAAA}), 1'b1);
      plan_item(exec_item(i_type(OP_ADDIU, 5'd0, 5'd5, 16'h1234)), 1'b0);
      plan_item(exec_item(i_type(OP_SW, 5'd0, 5'd7, 16'h0200)), 1'b0);
      plan_item(exec_item(i_type(OP_BEQ, 5'd0, 5'd0, 16'h0010)), 1'b0);
      plan_item(mem_item(FUNC_PRELOAD, 16'h0300, 32'hCAFE_F00D), 1'b0);
      plan_item(mem_item(FUNC_READ, 16'h0300, 32'h0), 1'b0);
      plan_item(mem_item(FUNC_NONE, 16'h0000, 32'h0), 1'b0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (program_items.size() != 0 || req_valid) @(posedge clock);
      while (predicted_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
